// ===== hdl/fpo_pkg.sv =====
// ----------------------------------------------------------------------------
// fpo_pkg
// Shared widths, register indexes, reset values, the cosine table builder and
// the control word types of the forced phase oscillator unit.
// ----------------------------------------------------------------------------
package fpo_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int TBL_SIZE       = 1 << COS_TABLE_BITS;

  localparam int GAIN_W  = 31;
  localparam int PHASE_W = 32;
  localparam int DAY_W   = 16;
  localparam int COUNT_W = 32;
  localparam int SIN_W   = 16;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_COUPLING_GAIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FREQ_INCREMENT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEPS_PER_DAY  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_STEPS    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_PHASE     = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = '0;
  localparam logic [PHASE_W-1:0] FREQ_RST  = 32'd2863312;
  localparam logic [DAY_W-1:0]   SPD_RST   = 16'd1000;
  localparam logic [DAY_W-1:0]   LIGHT_RST = 16'd500;
  localparam logic [PHASE_W-1:0] INIT_RST  = 32'd1431655765;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  typedef struct packed {
    logic [GAIN_W-1:0]  coupling_gain;
    logic [PHASE_W-1:0] freq_increment;
    logic [DAY_W-1:0]   steps_per_day;
    logic [DAY_W-1:0]   light_steps;
    logic [PHASE_W-1:0] init_phase;
  } cfg_t;

  typedef logic signed [SIN_W-1:0] cos_word_t;
  typedef cos_word_t cos_tbl_t [TBL_SIZE];

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_START,
    OP_MUL,
    OP_SLOPE,
    OP_PREP,
    OP_DIV_HI,
    OP_DIV_LO,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    ARG_HALF,
    ARG_FULL,
    ARG_KEEP
  } arg_sel_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_IN,
    J_OUT
  } jump_t;

  localparam int PROG_LEN = 19;
  localparam int PC_W     = $clog2(PROG_LEN);

  typedef struct packed {
    op_t      op;
    logic     weight2;
    arg_sel_t arg_sel;
  } ctrl_t;

  typedef struct packed {
    ctrl_t            ctl;
    jump_t            jump;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stat_t;

  // Cosine of a turn angle in Q0.32, Q1.15 rounded to nearest, from an
  // integer Taylor series evaluated in Horner form.
  function automatic cos_word_t series_cos(logic [31:0] ang);
    logic [63:0] r;
    logic        neg;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] pr;
    longint      t;
    longint      p;
    longint      q;
    int          i;
    r   = {32'b0, ang};
    neg = 1'b0;
    if (r > 64'h8000_0000) r = 64'h1_0000_0000 - r;
    if (r > 64'h4000_0000) begin
      r   = 64'h8000_0000 - r;
      neg = 1'b1;
    end
    th = (r * 64'd3373259426) >> 31;
    x2 = (th * th) >> 30;
    t  = 64'sd1073741824;
    for (i = 0; i < 6; i++) begin
      pr = (x2 * $unsigned(t)) >> 30;
      case (i)
        0:       p = $signed(pr) / 132;
        1:       p = $signed(pr) / 90;
        2:       p = $signed(pr) / 56;
        3:       p = $signed(pr) / 30;
        4:       p = $signed(pr) / 12;
        default: p = $signed(pr) / 2;
      endcase
      t = 64'sd1073741824 - p;
      if (t < 0 && i < 5) t = 0;
    end
    if (t < 0) t = 0;
    if (t > 64'sd1073741824) t = 64'sd1073741824;
    q = (t + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (neg) q = -q;
    return cos_word_t'(q[SIN_W-1:0]);
  endfunction

  function automatic cos_tbl_t build_cos_table();
    cos_tbl_t tbl;
    int       i;
    for (i = 0; i < TBL_SIZE; i++) begin
      tbl[i] = series_cos(32'(i) << (32 - COS_TABLE_BITS));
    end
    return tbl;
  endfunction

endpackage

// ===== hdl/fpo_cos_rom.sv =====
// ----------------------------------------------------------------------------
// fpo_cos_rom
// Full-turn cosine ROM in Q1.15 with a registered read port.
// ----------------------------------------------------------------------------
module fpo_cos_rom (
  input  logic                                clk,
  input  logic [fpo_pkg::COS_TABLE_BITS-1:0]  addr,
  output fpo_pkg::cos_word_t                  data
);
  import fpo_pkg::*;

  localparam cos_tbl_t COS_ROM = build_cos_table();

  always_ff @(posedge clk) begin
    data <= COS_ROM[addr];
  end

endmodule

// ===== hdl/fpo_useq.sv =====
// ----------------------------------------------------------------------------
// fpo_useq
// Microcode sequencer: a program counter walks a read-only table of control
// words; handshake steps hold until their beat can move.
// ----------------------------------------------------------------------------
module fpo_useq (
  input  logic            clk,
  input  logic            rst,
  input  fpo_pkg::stat_t  stat,
  output fpo_pkg::ctrl_t  ctrl,
  output logic            in_ready
);
  import fpo_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uw;
  logic            fire;

  function automatic uword_t mk(op_t op, logic w2, arg_sel_t sel, jump_t j,
                                logic [PC_W-1:0] tgt);
    uword_t u;
    u.ctl.op      = op;
    u.ctl.weight2 = w2;
    u.ctl.arg_sel = sel;
    u.jump        = j;
    u.target      = tgt;
    return u;
  endfunction

  // One RK4 slope takes three steps: wait for the ROM, multiply, then
  // accumulate the weighted slope and form the next lookup argument.
  function automatic uword_t ucode(logic [PC_W-1:0] a);
    uword_t u;
    unique case (a)
      5'd0:    u = mk(OP_START,  1'b0, ARG_KEEP, J_IN,   5'd1);
      5'd1:    u = mk(OP_NOP,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd2:    u = mk(OP_MUL,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd3:    u = mk(OP_SLOPE,  1'b0, ARG_HALF, J_NEXT, 5'd0);
      5'd4:    u = mk(OP_NOP,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd5:    u = mk(OP_MUL,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd6:    u = mk(OP_SLOPE,  1'b1, ARG_HALF, J_NEXT, 5'd0);
      5'd7:    u = mk(OP_NOP,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd8:    u = mk(OP_MUL,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd9:    u = mk(OP_SLOPE,  1'b1, ARG_FULL, J_NEXT, 5'd0);
      5'd10:   u = mk(OP_NOP,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd11:   u = mk(OP_MUL,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd12:   u = mk(OP_SLOPE,  1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd13:   u = mk(OP_PREP,   1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd14:   u = mk(OP_DIV_HI, 1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd15:   u = mk(OP_DIV_LO, 1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd16:   u = mk(OP_UPDATE, 1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd17:   u = mk(OP_NOP,    1'b0, ARG_KEEP, J_NEXT, 5'd0);
      5'd18:   u = mk(OP_EMIT,   1'b0, ARG_KEEP, J_OUT,  5'd0);
      default: u = mk(OP_NOP,    1'b0, ARG_KEEP, J_ALWAYS, 5'd0);
    endcase
    return u;
  endfunction

  assign uw       = ucode(pc);
  assign in_ready = (uw.jump == J_IN);

  always_comb begin
    fire    = 1'b1;
    pc_next = pc + PC_W'(1);
    unique case (uw.jump)
      J_NEXT:   pc_next = pc + PC_W'(1);
      J_ALWAYS: pc_next = uw.target;
      J_IN: begin
        fire    = stat.in_valid;
        pc_next = stat.in_valid ? uw.target : pc;
      end
      J_OUT: begin
        fire    = stat.out_free;
        pc_next = stat.out_free ? uw.target : pc;
      end
    endcase
  end

  always_comb begin
    ctrl    = uw.ctl;
    ctrl.op = fire ? uw.ctl.op : OP_NOP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  // An item never starts right after another one.
  a_no_double_start: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_START |=> ctrl.op != OP_START)
    else $error("fpo_useq: two starts in a row");

  // After the result is handed over, the sequencer is back at the accept step.
  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_EMIT |=> in_ready)
    else $error("fpo_useq: not ready for input after emit");

endmodule

// ===== hdl/fpo_datapath.sv =====
// ----------------------------------------------------------------------------
// fpo_datapath
// Phase state, day and step counters, the shared gain multiplier, the RK4
// accumulator, the divide-by-six slice and the output register.
// ----------------------------------------------------------------------------
module fpo_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  fpo_pkg::cfg_t                      cfg,
  input  fpo_pkg::ctrl_t                     ctrl,
  input  logic                               restart,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [fpo_pkg::OUT_TDATA_W-1:0]    out_data,
  output logic                               out_free
);
  import fpo_pkg::*;

  localparam int B = COS_TABLE_BITS;

  logic [PHASE_W-1:0]        phase;
  logic [DAY_W-1:0]          day_pos;
  logic [COUNT_W-1:0]        step_count;
  logic                      light;
  logic [PHASE_W-1:0]        arg;
  logic signed [34:0]        acc;
  logic [45:0]               prod;
  logic                      prod_neg;
  logic [33:0]               dvd;
  logic                      div_neg;
  logic [16:0]               q_hi;
  logic [1:0]                rem;
  logic [PHASE_W-1:0]        quo;

  logic [B-1:0]              rom_addr;
  cos_word_t                 cos_q;
  logic [15:0]               c_abs;
  logic [46:0]               k_rnd;
  logic [30:0]               k_mag;
  logic signed [31:0]        k;
  logic signed [31:0]        k_half;
  logic signed [34:0]        k_term;
  logic signed [34:0]        acc_sum;
  logic [PHASE_W-1:0]        arg_step;
  logic [34:0]               acc_abs;
  logic [34:0]               acc_rnd;
  logic [18:0]               div_hi;
  logic [18:0]               div_lo;
  logic [PHASE_W-1:0]        inc;
  logic [PHASE_W-1:0]        phase_new;
  logic [DAY_W:0]            day_inc;
  logic [DAY_W-1:0]          day_next;
  logic [DAY_W-1:0]          day_eff;
  logic [PHASE_W-1:0]        phase_eff;

  // Nearest table entry of a turn angle, wrapping around the table.
  function automatic logic [B-1:0] cos_index(logic [PHASE_W-1:0] x);
    logic [B:0] v;
    v = x[PHASE_W-1 -: B+1] + (B+1)'(1);
    return v[B:1];
  endfunction

  // Divide a 19-bit value by three with a reciprocal multiply; the 17-bit quotient
  // is exact for values below 3*2^17. Returns the quotient above the two remainder bits.
  function automatic logic [18:0] div3(logic [18:0] v);
    logic [39:0] pm;
    logic [16:0] q;
    logic [20:0] back;
    pm   = {21'b0, v} * 40'd699051;
    q    = pm[37:21];
    back = {4'b0, q} + {3'b0, q, 1'b0};
    return {q, 2'(21'(v) - back)};
  endfunction

  assign rom_addr = cos_index(arg);

  fpo_cos_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (cos_q)
  );

  always_comb begin
    c_abs   = cos_q[SIN_W-1] ? 16'(-cos_q) : 16'(cos_q);
    k_rnd   = {1'b0, prod} + 47'd16384;
    k_mag   = k_rnd[45:15];
    k       = (prod_neg ^ ~light) ? -$signed({1'b0, k_mag}) : $signed({1'b0, k_mag});
    // Half slope truncates toward zero.
    k_half  = (k + $signed({31'b0, k[31]})) >>> 1;
    k_term  = ctrl.weight2 ? 35'(k) <<< 1 : 35'(k);
    acc_sum = acc + k_term;
    unique case (ctrl.arg_sel)
      ARG_HALF: arg_step = phase + PHASE_W'(k_half);
      ARG_FULL: arg_step = phase + PHASE_W'(k);
      default:  arg_step = arg;
    endcase

    acc_abs = acc[34] ? 35'(-acc) : 35'(acc);
    acc_rnd = acc_abs + 35'd3;
    div_hi  = div3({2'b0, dvd[33:17]});
    div_lo  = div3({rem, dvd[16:0]});

    inc       = div_neg ? -quo : quo;
    phase_new = phase + inc + cfg.freq_increment;

    day_inc  = {1'b0, day_pos} + 17'd1;
    day_next = (day_inc >= {1'b0, cfg.steps_per_day}) ? '0 : day_inc[DAY_W-1:0];

    day_eff   = restart ? '0 : day_pos;
    phase_eff = restart ? cfg.init_phase : phase;
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= INIT_RST;
      day_pos    <= '0;
      step_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_START: begin
          phase <= phase_eff;
          if (restart) begin
            day_pos    <= '0;
            step_count <= '0;
          end
        end
        OP_UPDATE: phase <= phase_new;
        OP_EMIT: begin
          step_count <= step_count + COUNT_W'(1);
          day_pos    <= day_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_START: begin
        light <= (day_eff <= cfg.light_steps);
        arg   <= phase_eff;
        acc   <= '0;
      end
      OP_MUL: begin
        prod     <= {15'b0, cfg.coupling_gain} * {31'b0, c_abs[14:0]};
        prod_neg <= cos_q[SIN_W-1];
      end
      OP_SLOPE: begin
        acc <= acc_sum;
        arg <= arg_step;
      end
      OP_PREP: begin
        dvd     <= acc_rnd[34:1];
        div_neg <= acc[34];
      end
      OP_DIV_HI: begin
        q_hi <= div_hi[18:2];
        rem  <= div_hi[1:0];
      end
      OP_DIV_LO: quo <= {q_hi[14:0], div_lo[18:2]};
      // Sine of the new phase is the cosine a quarter turn back.
      OP_UPDATE: arg <= phase_new - QUARTER_TURN;
      OP_EMIT:   out_data <= {7'b0, light, cos_q, step_count};
      default: begin
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_EMIT |-> (!out_valid || out_ready))
    else $error("fpo_datapath: result overwritten before it was taken");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_EMIT |=> out_valid)
    else $error("fpo_datapath: emitted result not presented");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_DIV_HI |=> rem != 2'd3)
    else $error("fpo_datapath: divide-by-three remainder out of range");

endmodule

// ===== hdl/forced_phase_oscillator_rk4_unit.sv =====
// ----------------------------------------------------------------------------
// forced_phase_oscillator_rk4_unit
// Square-wave forced phase oscillator advanced by one RK4 step per beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         restart (bit 0)
//  m_axis    out        step_index [31:0], sin_phase [47:32], light_on [48]
//  cfg       in         write enable, register index, 32-bit data
//
//  An input beat is taken at the accept step; its result is registered at the
//  emit step, and the next input beat can be taken in the cycle after that, so
//  a new item is not taken before the last one has been emitted.
//  Each item runs four slopes of three steps each (ROM read, gain
//  multiply, accumulate) on one ROM and one multiplier, plus the divide by
//  six and the sine lookup. A result waiting on m_axis holds the sequencer
//  only at its emit step. Reset is synchronous; it loads the register reset
//  values and the reset phase, and clears both counters.
// ----------------------------------------------------------------------------
module forced_phase_oscillator_rk4_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [fpo_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [0] restart
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] step_index, [47:32] sin_phase, [48] light_on
  output logic [fpo_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [fpo_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [fpo_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fpo_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;
  logic  out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coupling_gain  <= GAIN_RST;
      cfg.freq_increment <= FREQ_RST;
      cfg.steps_per_day  <= SPD_RST;
      cfg.light_steps    <= LIGHT_RST;
      cfg.init_phase     <= INIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COUPLING_GAIN:  cfg.coupling_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_FREQ_INCREMENT: cfg.freq_increment <= cfg_wdata[PHASE_W-1:0];
        REG_STEPS_PER_DAY:  cfg.steps_per_day  <= cfg_wdata[DAY_W-1:0];
        REG_LIGHT_STEPS:    cfg.light_steps    <= cfg_wdata[DAY_W-1:0];
        REG_INIT_PHASE:     cfg.init_phase     <= cfg_wdata[PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign stat.in_valid = s_axis_tvalid;
  assign stat.out_free = out_free;

  fpo_useq u_seq (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (s_axis_tready)
  );

  fpo_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .restart   (s_axis_tdata[0]),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_free  (out_free)
  );

endmodule

// ===== sim/forced_phase_oscillator_rk4_unit_tb.sv =====
// ----------------------------------------------------------------------------
// forced_phase_oscillator_rk4_unit_tb
// Self-checking bench for the RK4 forced phase oscillator. A bit-true
// predictor in the bench mirrors the cosine table and the RK4 step, and
// every output beat is checked against the oldest prediction. Directed
// register extremes and day-wrap corners come first. Random register
// settings follow under four patterns of source idling and sink stalls.
// ----------------------------------------------------------------------------
module forced_phase_oscillator_rk4_unit_tb;
  import fpo_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_BLOCKS  = 8;
  localparam int BLOCK_ITEMS    = 56;

  // Indexes past the end of the register map; writes there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam logic [PHASE_W-1:0]  FREQ_DEFAULT  = 32'd2863312;
  localparam logic [DAY_W-1:0]    DAY_DEFAULT   = 16'd1000;
  localparam logic [DAY_W-1:0]    LIGHT_DEFAULT = 16'd500;
  localparam logic [PHASE_W-1:0]  INIT_DEFAULT  = 32'd1431655765;
  localparam longint unsigned     PI_Q30        = 64'd3373259426;
  localparam longint              ONE_Q30       = 64'sd1073741824;

  typedef struct packed {
    logic [COUNT_W-1:0] step_index;
    cos_word_t          sin_phase;
    logic               light_on;
  } tick_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Predictor state: register copy, oscillator state and cosine table.
  cfg_t               osc_cfg;
  logic [PHASE_W-1:0] osc_phase;
  int unsigned        day_pos;
  logic [COUNT_W-1:0] step_cnt;
  cos_word_t          cos_rom [TBL_SIZE];

  tick_t expected_ticks [$];
  tick_t seen_tick;
  tick_t want_tick;

  int failures       = 0;
  int ticks_checked  = 0;
  int steps_sent     = 0;
  int restarts_sent  = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  forced_phase_oscillator_rk4_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [0] restart
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [31:0] step_index, [47:32] sin_phase, [48] light_on
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Cosine of a Q0.32 turn angle in Q1.15, from a seven-term integer series.
  function automatic cos_word_t exact_cos(input logic [31:0] ang);
    longint unsigned r;
    longint unsigned th;
    longint unsigned x2;
    longint unsigned pr;
    longint          t;
    longint          p;
    longint          q;
    logic            flip;
    int              i;
    r    = {32'b0, ang};
    flip = 1'b0;
    if (r > 64'h8000_0000) r = 64'h1_0000_0000 - r;
    if (r > 64'h4000_0000) begin
      r    = 64'h8000_0000 - r;
      flip = 1'b1;
    end
    th = (r * PI_Q30) >> 31;
    x2 = (th * th) >> 30;
    t  = ONE_Q30;
    for (i = 0; i < 6; i++) begin
      pr = (x2 * longint'(t)) >> 30;
      case (i)
        0: p = longint'(pr) / 132;
        1: p = longint'(pr) / 90;
        2: p = longint'(pr) / 56;
        3: p = longint'(pr) / 30;
        4: p = longint'(pr) / 12;
        default: p = longint'(pr) / 2;
      endcase
      t = ONE_Q30 - p;
      if (t < 0 && i < 5) t = 0;
    end
    if (t < 0) t = 0;
    if (t > ONE_Q30) t = ONE_Q30;
    q = (t + 16384) >>> 15;
    if (q > 32767) q = 32767;
    return cos_word_t'(flip ? -q : q);
  endfunction

  // Nearest table entry to the angle, wrapping at one turn.
  function automatic cos_word_t rom_cos(input logic [PHASE_W-1:0] x);
    logic [31:0] idx;
    idx = ((x >> (31 - COS_TABLE_BITS)) + 32'd1) >> 1;
    return cos_rom[idx[COS_TABLE_BITS-1:0]];
  endfunction

  // Coupling slope in signed Q0.32 turns; dark flips the sign of the drive.
  function automatic longint gain_slope(input logic [PHASE_W-1:0] x, input logic light);
    cos_word_t       c;
    logic            neg;
    longint unsigned mag;
    longint unsigned m;
    c   = rom_cos(x);
    neg = (c < 0);
    mag = neg ? longint'(-longint'(c)) : longint'(c);
    m   = (longint'({33'b0, osc_cfg.coupling_gain}) * mag + 64'd16384) >> 15;
    if (!light) neg = !neg;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // One RK4 step of the oscillator; returns the beat the block should emit.
  function automatic tick_t rk4_tick(input logic restart);
    tick_t  res;
    logic   light;
    longint k1;
    longint k2;
    longint k3;
    longint k4;
    longint total;
    longint q;
    if (restart) begin
      osc_phase = osc_cfg.init_phase;
      day_pos   = 0;
      step_cnt  = '0;
    end
    light = (day_pos <= osc_cfg.light_steps);
    k1 = gain_slope(osc_phase, light);
    k2 = gain_slope(osc_phase + 32'(k1 / 2), light);
    k3 = gain_slope(osc_phase + 32'(k2 / 2), light);
    k4 = gain_slope(osc_phase + 32'(k3), light);
    total = k1 + 2 * k2 + 2 * k3 + k4;
    q = ((total < 0 ? -total : total) + 3) / 6;
    if (total < 0) q = -q;
    osc_phase = osc_phase + 32'(q) + osc_cfg.freq_increment;
    res.step_index = step_cnt;
    res.sin_phase  = rom_cos(osc_phase - QUARTER_TURN);
    res.light_on   = light;
    step_cnt = step_cnt + 1'b1;
    day_pos  = day_pos + 1;
    if (day_pos >= osc_cfg.steps_per_day) day_pos = 0;
    return res;
  endfunction

  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10) $display("ERROR at %0t: %s", $time, what);
  endtask

  // Offers one beat, with random idle cycles in front of it, and waits for
  // the handshake. tvalid stays high so a following beat can go back to back.
  task automatic send_step(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_ticks.push_back(rk4_tick(restart));
    steps_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_COUPLING_GAIN:  osc_cfg.coupling_gain  = value[GAIN_W-1:0];
      REG_FREQ_INCREMENT: osc_cfg.freq_increment = value[PHASE_W-1:0];
      REG_STEPS_PER_DAY:  osc_cfg.steps_per_day  = value[DAY_W-1:0];
      REG_LIGHT_STEPS:    osc_cfg.light_steps    = value[DAY_W-1:0];
      REG_INIT_PHASE:     osc_cfg.init_phase     = value[PHASE_W-1:0];
      default: ;
    endcase
  endtask

  // Reset values: zero gain, so only the free-running advance and the
  // table are seen; the first step runs from the reset phase.
  task automatic test_reset_state();
    drain_results();
    settings_used++;
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
  endtask

  task automatic test_register_extremes();
    drain_results();
    settings_used++;
    // All ones into the gain register also checks that its top bit is dropped.
    write_reg(REG_COUPLING_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_FREQ_INCREMENT, 32'hFFFF_FFFF);
    write_reg(REG_STEPS_PER_DAY, 32'hFFFF_0003);
    write_reg(REG_LIGHT_STEPS, 32'hABCD_0000);
    write_reg(REG_INIT_PHASE, 32'h0000_0000);
    send_step(1'b1);
    repeat (4) send_step(1'b0);
    drain_results();
    settings_used++;
    write_reg(REG_FREQ_INCREMENT, 32'h0000_0000);
    write_reg(REG_INIT_PHASE, 32'hFFFF_FFFF);
    send_step(1'b1);
    send_step(1'b0);
  endtask

  task automatic test_day_edges();
    drain_results();
    settings_used++;
    // A zero-length day acts as a one-step day, so every step is light.
    write_reg(REG_STEPS_PER_DAY, 32'd0);
    write_reg(REG_LIGHT_STEPS, 32'd0);
    write_reg(REG_COUPLING_GAIN, 32'h1234_5678);
    write_reg(REG_FREQ_INCREMENT, 32'h0100_0000);
    send_step(1'b1);
    repeat (2) send_step(1'b0);
    drain_results();
    settings_used++;
    write_reg(REG_STEPS_PER_DAY, 32'd65535);
    write_reg(REG_LIGHT_STEPS, 32'd65535);
    send_step(1'b0);
    send_step(1'b1);
    drain_results();
    settings_used++;
    // Light length past the end of the day: light throughout.
    write_reg(REG_STEPS_PER_DAY, 32'd4);
    write_reg(REG_LIGHT_STEPS, 32'd9);
    repeat (5) send_step(1'b0);
  endtask

  task automatic test_spare_indexes();
    drain_results();
    write_reg(REG_SPARE_FIRST, 32'hDEAD_BEEF);
    write_reg(REG_SPARE_LAST, 32'hFFFF_FFFF);
    send_step(1'b0);
    send_step(1'b1);
  endtask

  task automatic test_random_operation();
    int                    blk;
    int                    n;
    logic [CFG_DATA_W-1:0] gain_w;
    logic [CFG_DATA_W-1:0] freq_w;
    int unsigned           spd;
    int unsigned           lit;
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      drain_results();
      settings_used++;
      case (blk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      case ($urandom_range(3))
        0: gain_w = '0;
        1: gain_w = 32'h7FFF_FFFF | ($urandom & 32'h8000_0000);
        2: gain_w = $urandom;
        default: gain_w = $urandom_range(32'h0100_0000);
      endcase
      case ($urandom_range(3))
        0: freq_w = '0;
        1: freq_w = 32'hFFFF_FFFF;
        default: freq_w = $urandom;
      endcase
      case ($urandom_range(7))
        0: spd = 0;
        1: spd = 65535;
        default: spd = $urandom_range(1, 40);
      endcase
      if ($urandom_range(7) == 0) lit = 65535;
      else lit = $urandom_range(0, (spd > 40 ? 40 : spd) + 2);
      write_reg(REG_COUPLING_GAIN, gain_w);
      write_reg(REG_FREQ_INCREMENT, freq_w);
      write_reg(REG_STEPS_PER_DAY, {16'($urandom_range(65535)), spd[15:0]});
      write_reg(REG_LIGHT_STEPS, {16'($urandom_range(65535)), lit[15:0]});
      write_reg(REG_INIT_PHASE, $urandom);
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        send_step(n == 0 || $urandom_range(24) == 0);
      end
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_tick.step_index = m_axis_tdata[31:0];
      seen_tick.sin_phase  = m_axis_tdata[47:32];
      seen_tick.light_on   = m_axis_tdata[48];
      ticks_checked++;
      if (expected_ticks.size() == 0) begin
        report_failure($sformatf("result beat with nothing expected: step %0d sin %0d light %0b",
                                 seen_tick.step_index, seen_tick.sin_phase,
                                 seen_tick.light_on));
      end else begin
        want_tick = expected_ticks.pop_front();
        if (seen_tick.step_index !== want_tick.step_index ||
            seen_tick.sin_phase !== want_tick.sin_phase ||
            seen_tick.light_on !== want_tick.light_on) begin
          report_failure($sformatf(
            "step_index exp %0d got %0d, sin_phase exp %0d got %0d, light_on exp %0b got %0b",
            want_tick.step_index, seen_tick.step_index, want_tick.sin_phase,
            seen_tick.sin_phase, want_tick.light_on, seen_tick.light_on));
        end
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_ticks.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < TBL_SIZE; i++) begin
      cos_rom[i] = exact_cos(32'(i) << (32 - COS_TABLE_BITS));
    end
    osc_cfg.coupling_gain  = '0;
    osc_cfg.freq_increment = FREQ_DEFAULT;
    osc_cfg.steps_per_day  = DAY_DEFAULT;
    osc_cfg.light_steps    = LIGHT_DEFAULT;
    osc_cfg.init_phase     = INIT_DEFAULT;
    osc_phase = INIT_DEFAULT;
    day_pos   = 0;
    step_cnt  = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_register_extremes();
    test_day_edges();
    test_spare_indexes();
    test_random_operation();
    drain_results();

    if (expected_ticks.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived", expected_ticks.size()));
    end
    $display("Ran %0d RK4 steps (%0d with restart) over %0d register settings,",
             steps_sent, restarts_sent, settings_used);
    $display("with and without source idling and sink stalls; %0d result beats checked,",
             ticks_checked);
    $display("%0d failures.", failures);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fpo_pkg.sv
hdl/fpo_cos_rom.sv
hdl/fpo_useq.sv
hdl/fpo_datapath.sv
hdl/forced_phase_oscillator_rk4_unit.sv
sim/forced_phase_oscillator_rk4_unit_tb.sv
